// File: sv/sha256c_pkg.sv
// Shared types, constants and round functions of the SHA-256 block compressor.
package sha256c_pkg;

   localparam int WordW    = 32;
   localparam int WinDepth = 16;
   localparam int HashN    = 8;
   localparam int RoundsN  = 64;

   typedef logic [WordW-1:0]            word_type;
   typedef logic [$clog2(WinDepth)-1:0] widx_type;
   typedef logic [$clog2(RoundsN)-1:0]  round_type;
   typedef logic [$clog2(HashN)-1:0]    hidx_type;
   typedef word_type [HashN-1:0]        hash_type;

   // one schedule memory access slot driven by the sequencer
   typedef struct packed {
      logic      valid;
      logic      phase;
      round_type rnd;
   } issue_type;

   // schedule word plus round constant handed to the round unit
   typedef struct packed {
      logic     valid;
      logic     last;
      word_type kw;
   } sched_out_type;

   localparam word_type InitHash [HashN] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type RoundK [RoundsN] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (WordW - n));
   endfunction

   function automatic word_type small_sig0(input word_type x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sig1(input word_type x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type big_sig0(input word_type x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sig1(input word_type x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type choose(input word_type e, input word_type f,
                                       input word_type g);
      return (e & f) ^ (~e & g);
   endfunction

   function automatic word_type majority(input word_type a, input word_type b,
                                         input word_type c);
      return (a & b) ^ (a & c) ^ (b & c);
   endfunction

endpackage

// File: sv/sha256_block_compressor.sv
// SHA-256 block compressor: message words in, eight digest words out per message.
// Words of a padded message are taken one per cycle into a 16-entry schedule
// memory; the sixteenth word of a block starts compression and the input stalls
// until the block is folded into the hash. Each of the 64 rounds splits its
// schedule reads into a phase 0 and a phase 1 because the schedule memory has two
// read ports and the expansion of W[t] needs four window words. The
// end-of-message mark is sampled only on the sixteenth word of a block; when set,
// the digest is copied into an output buffer and drained H0..H7 while the next
// message loads, with the last word flagged. A block ending a message waits only
// if the previous digest has not yet been fully taken.
module sha256_block_compressor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_message_word,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_last_word
);

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_FINAL = 2'd2;

   logic [1:0]                 state_ff;
   logic [1:0]                 state_in;
   sha256c_pkg::widx_type      cnt_ff;
   sha256c_pkg::round_type     rnd_ff;
   logic                       phase_ff;
   logic                       issuing_ff;
   logic                       eom_ff;
   sha256c_pkg::hash_type      hash_ff;
   sha256c_pkg::hash_type      sum;
   sha256c_pkg::hash_type      dig_ff;
   logic                       out_busy_ff;
   sha256c_pkg::hidx_type      out_idx_ff;

   logic                       req_accept;
   logic                       rsp_accept;
   logic                       block_done;
   logic                       load_vars;
   sha256c_pkg::issue_type     issue;
   sha256c_pkg::sched_out_type sched_out;
   sha256c_pkg::hash_type      working_vars;

   assign req_stall  = (state_ff != ST_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign load_vars  = req_accept && (cnt_ff == sha256c_pkg::widx_type'(sha256c_pkg::WinDepth - 1));
   assign block_done = sched_out.valid && sched_out.last;

   assign issue.valid = issuing_ff;
   assign issue.phase = phase_ff;
   assign issue.rnd   = rnd_ff;

   sha256c_sched u_sched (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .ld_en     (req_accept),
      .ld_addr   (cnt_ff),
      .ld_data   (req_message_word),
      .sched_out (sched_out)
   );

   sha256c_round u_round (
      .clock        (clock),
      .load         (load_vars),
      .hash_words   (hash_ff),
      .step         (sched_out),
      .working_vars (working_vars)
   );

   always_comb begin
      for (int j = 0; j < sha256c_pkg::HashN; j++) begin
         sum[j] = hash_ff[j] + working_vars[j];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (load_vars) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (block_done) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (!eom_ff || !out_busy_ff) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         cnt_ff      <= '0;
         rnd_ff      <= '0;
         phase_ff    <= 1'b0;
         issuing_ff  <= 1'b0;
         eom_ff      <= 1'b0;
         out_busy_ff <= 1'b0;
         out_idx_ff  <= '0;
         for (int j = 0; j < sha256c_pkg::HashN; j++) begin
            hash_ff[j] <= sha256c_pkg::InitHash[j];
         end
      end else begin
         state_ff <= state_in;
         if (req_accept) begin
            cnt_ff <= sha256c_pkg::widx_type'(cnt_ff + 1'b1);
         end
         if (load_vars) begin
            eom_ff     <= req_end_of_message;
            rnd_ff     <= '0;
            phase_ff   <= 1'b0;
            issuing_ff <= 1'b1;
         end else if (issuing_ff) begin
            phase_ff <= !phase_ff;
            if (phase_ff) begin
               rnd_ff <= sha256c_pkg::round_type'(rnd_ff + 1'b1);
               if (rnd_ff == sha256c_pkg::round_type'(sha256c_pkg::RoundsN - 1)) begin
                  issuing_ff <= 1'b0;
               end
            end
         end
         if (rsp_accept) begin
            out_idx_ff <= sha256c_pkg::hidx_type'(out_idx_ff + 1'b1);
            if (out_idx_ff == sha256c_pkg::hidx_type'(sha256c_pkg::HashN - 1)) begin
               out_busy_ff <= 1'b0;
            end
         end
         if (state_ff == ST_FINAL) begin
            if (!eom_ff) begin
               hash_ff <= sum;
            end else if (!out_busy_ff) begin
               // digest goes to the drain buffer, hash restarts for the next message
               out_busy_ff <= 1'b1;
               out_idx_ff  <= '0;
               for (int j = 0; j < sha256c_pkg::HashN; j++) begin
                  hash_ff[j] <= sha256c_pkg::InitHash[j];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FINAL && eom_ff && !out_busy_ff) begin
         dig_ff <= sum;
      end
   end

   assign rsp_valid       = out_busy_ff;
   assign rsp_digest_word = dig_ff[out_idx_ff];
   assign rsp_last_word   = (out_idx_ff == sha256c_pkg::hidx_type'(sha256c_pkg::HashN - 1));

endmodule

// File: sv/sha256c_wmem.sv
// Schedule window memory: one write port, two registered read ports.
module sha256c_wmem (
   input  logic                 clock,
   input  logic                 wr_en,
   input  sha256c_pkg::widx_type wr_addr,
   input  sha256c_pkg::word_type wr_data,
   input  sha256c_pkg::widx_type rd_addr0,
   input  sha256c_pkg::widx_type rd_addr1,
   output sha256c_pkg::word_type rd_data0,
   output sha256c_pkg::word_type rd_data1
);

   sha256c_pkg::word_type mem [sha256c_pkg::WinDepth];
   sha256c_pkg::word_type rd0_ff;
   sha256c_pkg::word_type rd1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd0_ff <= mem[rd_addr0];
      rd1_ff <= mem[rd_addr1];
   end

   assign rd_data0 = rd0_ff;
   assign rd_data1 = rd1_ff;

endmodule

// File: sv/sha256c_sched.sv
// Message schedule unit: reads the window memory in two phases per round,
// expands W[t] for rounds 16..63, writes it back and adds the round constant.
module sha256c_sched (
   input  logic                       clock,
   input  logic                       reset,
   input  sha256c_pkg::issue_type     issue,
   input  logic                       ld_en,
   input  sha256c_pkg::widx_type      ld_addr,
   input  sha256c_pkg::word_type      ld_data,
   output sha256c_pkg::sched_out_type sched_out
);

   sha256c_pkg::widx_type      base;
   sha256c_pkg::widx_type      rd_addr0;
   sha256c_pkg::widx_type      rd_addr1;
   sha256c_pkg::word_type      rd_data0;
   sha256c_pkg::word_type      rd_data1;
   logic                       wr_en;
   sha256c_pkg::widx_type      wr_addr;
   sha256c_pkg::word_type      wr_data;

   logic                       a_valid_ff;
   sha256c_pkg::round_type     a_rnd_ff;
   logic                       b_valid_ff;
   sha256c_pkg::round_type     b_rnd_ff;
   sha256c_pkg::word_type      part_ff;
   sha256c_pkg::word_type      part_in;
   sha256c_pkg::word_type      wt;
   logic                       b_expand;
   sha256c_pkg::sched_out_type out_ff;
   sha256c_pkg::sched_out_type out_in;

   // phase 0 fetches W[t-16], W[t-15]; phase 1 fetches W[t-7], W[t-2]
   assign base = issue.rnd[$bits(sha256c_pkg::widx_type)-1:0];

   always_comb begin
      if (!issue.phase) begin
         rd_addr0 = base;
         rd_addr1 = sha256c_pkg::widx_type'(base + 4'd1);
      end else begin
         rd_addr0 = sha256c_pkg::widx_type'(base + 4'd9);
         rd_addr1 = sha256c_pkg::widx_type'(base + 4'd14);
      end
   end

   always_comb begin
      if (a_rnd_ff >= sha256c_pkg::round_type'(sha256c_pkg::WinDepth)) begin
         part_in = rd_data0 + sha256c_pkg::small_sig0(rd_data1);
      end else begin
         part_in = rd_data0;
      end
   end

   assign b_expand = (b_rnd_ff >= sha256c_pkg::round_type'(sha256c_pkg::WinDepth));

   always_comb begin
      if (b_expand) begin
         wt = part_ff + rd_data0 + sha256c_pkg::small_sig1(rd_data1);
      end else begin
         wt = part_ff;
      end
      out_in.valid = b_valid_ff;
      out_in.last  = (b_rnd_ff == sha256c_pkg::round_type'(sha256c_pkg::RoundsN - 1));
      out_in.kw    = wt + sha256c_pkg::RoundK[b_rnd_ff];
   end

   // load writes and expanded writes never share a cycle
   always_comb begin
      if (ld_en) begin
         wr_en   = 1'b1;
         wr_addr = ld_addr;
         wr_data = ld_data;
      end else begin
         wr_en   = b_valid_ff && b_expand;
         wr_addr = b_rnd_ff[$bits(sha256c_pkg::widx_type)-1:0];
         wr_data = wt;
      end
   end

   sha256c_wmem u_wmem (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         out_ff     <= '0;
      end else begin
         a_valid_ff <= issue.valid && !issue.phase;
         b_valid_ff <= issue.valid && issue.phase;
         out_ff     <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      a_rnd_ff <= issue.rnd;
      b_rnd_ff <= a_rnd_ff;
      if (a_valid_ff) begin
         part_ff <= part_in;
      end
   end

   assign sched_out = out_ff;

endmodule

// File: sv/sha256c_round.sv
// Round unit: holds the working variables a..h and applies one round per step.
module sha256c_round (
   input  logic                       clock,
   input  logic                       load,
   input  sha256c_pkg::hash_type      hash_words,
   input  sha256c_pkg::sched_out_type step,
   output sha256c_pkg::hash_type      working_vars
);

   sha256c_pkg::hash_type vars_ff;
   sha256c_pkg::hash_type vars_in;
   sha256c_pkg::word_type t1;
   sha256c_pkg::word_type t2;

   always_comb begin
      t1 = vars_ff[7] + sha256c_pkg::big_sig1(vars_ff[4])
         + sha256c_pkg::choose(vars_ff[4], vars_ff[5], vars_ff[6]) + step.kw;
      t2 = sha256c_pkg::big_sig0(vars_ff[0])
         + sha256c_pkg::majority(vars_ff[0], vars_ff[1], vars_ff[2]);
      vars_in    = vars_ff;
      vars_in[7] = vars_ff[6];
      vars_in[6] = vars_ff[5];
      vars_in[5] = vars_ff[4];
      vars_in[4] = vars_ff[3] + t1;
      vars_in[3] = vars_ff[2];
      vars_in[2] = vars_ff[1];
      vars_in[1] = vars_ff[0];
      vars_in[0] = t1 + t2;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         vars_ff <= hash_words;
      end else if (step.valid) begin
         vars_ff <= vars_in;
      end
   end

   assign working_vars = vars_ff;

endmodule
